// ----- rtl/adc_ladder_keypad_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// adc_ladder_keypad_decoder_defines.svh
// Assertion macros for the keypad decoder. Assertions compile out when
// ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ADC_LADDER_KEYPAD_DECODER_DEFINES_SVH
`define ADC_LADDER_KEYPAD_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only outside reset
`define ALKD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// checked at every edge, reset included
`define ALKD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define ALKD_ASSERT(label, prop, msg)
`define ALKD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ----- rtl/alkd_pkg.sv -----
// ----------------------------------------------------------------------------
// alkd_pkg
// Shared types, codes and reset values of the keypad decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package alkd_pkg;

   // default sizes
   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_ADC_BITS    = 8;
   localparam int DEF_COUNT_BITS  = 16;

   // fixed field widths
   localparam int CODE_W    = 4;
   localparam int BAND_W    = 3;
   localparam int THR_W     = 8;
   localparam int LIMIT_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // request types
   typedef enum logic [1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_READ   = 2'd1,
      REQ_INJECT = 2'd2,
      REQ_NOP    = 2'd3
   } req_kind_type;

   // band codes
   localparam logic [BAND_W-1:0] BAND_GAP     = 3'd0;
   localparam logic [BAND_W-1:0] BAND_KEY1    = 3'd1;
   localparam logic [BAND_W-1:0] BAND_KEY2    = 3'd2;
   localparam logic [BAND_W-1:0] BAND_KEY3    = 3'd3;
   localparam logic [BAND_W-1:0] BAND_KEY4    = 3'd4;
   localparam logic [BAND_W-1:0] BAND_RELEASE = 3'd5;

   // offset from short code to long code
   localparam logic [CODE_W-1:0] LONG_OFFSET = 4'd4;
   localparam logic [CODE_W-1:0] CODE_NONE   = 4'd0;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BAND1_UPPER    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BAND2_UPPER    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BAND3_UPPER    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BAND4_UPPER    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_ABOVE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE_COUNT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_COUNT     = 3'd6;

   // register reset values
   localparam logic [THR_W-1:0]   RST_BAND1_UPPER    = 8'd100;
   localparam logic [THR_W-1:0]   RST_BAND2_UPPER    = 8'd140;
   localparam logic [THR_W-1:0]   RST_BAND3_UPPER    = 8'd180;
   localparam logic [THR_W-1:0]   RST_BAND4_UPPER    = 8'd240;
   localparam logic [THR_W-1:0]   RST_RELEASE_ABOVE  = 8'd245;
   localparam logic [LIMIT_W-1:0] RST_DEBOUNCE_COUNT = 16'd3;
   localparam logic [LIMIT_W-1:0] RST_LONG_COUNT     = 16'd30;

   // register write word
   typedef struct packed {
      logic                 en;
      logic [CSR_IDX_W-1:0] index;
      logic [CSR_DAT_W-1:0] data;
   } cfg_wr_type;

   // press event from the tracker
   typedef struct packed {
      logic              push;
      logic [CODE_W-1:0] code;
   } event_type;

   // command to the key ring
   typedef struct packed {
      logic              en;
      logic              push;
      logic [CODE_W-1:0] push_code;
      logic              pop;
   } qcmd_type;

endpackage

`default_nettype wire

// ----- rtl/alkd_channels.sv -----
// ----------------------------------------------------------------------------
// alkd_channels
// Valid/ready channel interfaces of the keypad decoder.
// ----------------------------------------------------------------------------
`default_nettype none

// request channel
interface alkd_req_if #(parameter int ADC_BITS = alkd_pkg::DEF_ADC_BITS);
   logic                valid;
   logic                ready;
   logic [1:0]          req_type;
   logic [ADC_BITS-1:0] adc_sample;
   logic [3:0]          inject_code;

   modport source (output valid, req_type, adc_sample, inject_code, input ready);
   modport sink   (input valid, req_type, adc_sample, inject_code, output ready);
endinterface

// response channel
interface alkd_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] key_code;
   logic [2:0] band;
   logic       event_pushed;

   modport source (output valid, key_code, band, event_pushed, input ready);
   modport sink   (input valid, key_code, band, event_pushed, output ready);
endinterface

// register write channel
interface alkd_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/alkd_tracker.sv -----
// ----------------------------------------------------------------------------
// alkd_tracker
// Band classifier, configuration registers and dominant-band tracking with
// short and long press detection.
// ----------------------------------------------------------------------------
`default_nettype none

module alkd_tracker #(
   parameter int ADC_BITS   = alkd_pkg::DEF_ADC_BITS,
   parameter int COUNT_BITS = alkd_pkg::DEF_COUNT_BITS
) (
   input  wire                              clock,
   input  wire                              reset,
   input  alkd_pkg::cfg_wr_type             cfg,
   input  wire                              sample_en,
   input  wire  [ADC_BITS-1:0]              sample,
   output logic [alkd_pkg::BAND_W-1:0]      band,
   output alkd_pkg::event_type              evt
);

   // common width for count vs limit compares
   localparam int CMP_W = (COUNT_BITS > alkd_pkg::LIMIT_W) ? COUNT_BITS : alkd_pkg::LIMIT_W;
   localparam logic [COUNT_BITS-1:0] CNT_SAT = {COUNT_BITS{1'b1}};

   logic [alkd_pkg::THR_W-1:0]   band1_ff, band2_ff, band3_ff, band4_ff, rel_ff;
   logic [alkd_pkg::LIMIT_W-1:0] deb_ff, long_ff;
   logic [alkd_pkg::BAND_W-1:0]  dom_ff, dom_in;
   logic [COUNT_BITS-1:0]        run_ff, run_in, mis_ff, mis_in;

   logic [ADC_BITS-1:0]          t1, t2, t3, t4, tr;
   logic                         is_rel, dom_key, push_short, push_long;
   logic [alkd_pkg::BAND_W-1:0]  dom_c;
   logic [COUNT_BITS-1:0]        run_c, mis_c, run_n, mis_n;
   logic [CMP_W-1:0]             run_x, run_nx, deb_x, long_x;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         band1_ff <= alkd_pkg::RST_BAND1_UPPER;
         band2_ff <= alkd_pkg::RST_BAND2_UPPER;
         band3_ff <= alkd_pkg::RST_BAND3_UPPER;
         band4_ff <= alkd_pkg::RST_BAND4_UPPER;
         rel_ff   <= alkd_pkg::RST_RELEASE_ABOVE;
         deb_ff   <= alkd_pkg::RST_DEBOUNCE_COUNT;
         long_ff  <= alkd_pkg::RST_LONG_COUNT;
      end else if (cfg.en) begin
         case (cfg.index)
            alkd_pkg::REG_BAND1_UPPER:    band1_ff <= cfg.data[alkd_pkg::THR_W-1:0];
            alkd_pkg::REG_BAND2_UPPER:    band2_ff <= cfg.data[alkd_pkg::THR_W-1:0];
            alkd_pkg::REG_BAND3_UPPER:    band3_ff <= cfg.data[alkd_pkg::THR_W-1:0];
            alkd_pkg::REG_BAND4_UPPER:    band4_ff <= cfg.data[alkd_pkg::THR_W-1:0];
            alkd_pkg::REG_RELEASE_ABOVE:  rel_ff   <= cfg.data[alkd_pkg::THR_W-1:0];
            alkd_pkg::REG_DEBOUNCE_COUNT: deb_ff   <= cfg.data;
            alkd_pkg::REG_LONG_COUNT:     long_ff  <= cfg.data;
            default: ;
         endcase
      end
   end

   // classify: first matching band wins
   always_comb begin
      t1 = ADC_BITS'(band1_ff);
      t2 = ADC_BITS'(band2_ff);
      t3 = ADC_BITS'(band3_ff);
      t4 = ADC_BITS'(band4_ff);
      tr = ADC_BITS'(rel_ff);
      if (sample < t1)                       band = alkd_pkg::BAND_KEY1;
      else if (sample < t2)                  band = alkd_pkg::BAND_KEY2;
      else if (sample >= t2 && sample < t3)  band = alkd_pkg::BAND_KEY3;
      else if (sample >= t3 && sample < t4)  band = alkd_pkg::BAND_KEY4;
      else if (sample > tr)                  band = alkd_pkg::BAND_RELEASE;
      else                                   band = alkd_pkg::BAND_GAP;
   end

   // run / mismatch update for one sample
   always_comb begin
      run_x  = CMP_W'(run_ff);
      deb_x  = CMP_W'(deb_ff);
      long_x = CMP_W'(long_ff);
      dom_key = (dom_ff >= alkd_pkg::BAND_KEY1) && (dom_ff <= alkd_pkg::BAND_KEY4);

      // debounced release: maybe a short press, then clear tracking
      is_rel     = (band == alkd_pkg::BAND_RELEASE) && (run_x > deb_x);
      push_short = is_rel && dom_key && (run_x < long_x);
      dom_c = is_rel ? alkd_pkg::BAND_GAP : dom_ff;
      run_c = is_rel ? '0 : run_ff;
      mis_c = is_rel ? '0 : mis_ff;

      run_n     = run_c;
      mis_n     = mis_c;
      push_long = 1'b0;
      if (band == dom_c) begin
         if (run_c != CNT_SAT) begin
            run_n = run_c + 1'b1;
         end
         run_nx    = CMP_W'(run_n);
         push_long = (run_c != CNT_SAT) && (run_nx == long_x) &&
                     (dom_c >= alkd_pkg::BAND_KEY1) && (dom_c <= alkd_pkg::BAND_KEY4);
      end else begin
         run_nx = CMP_W'(run_n);
         if (mis_c != CNT_SAT) begin
            mis_n = mis_c + 1'b1;
         end
      end

      dom_in = (run_n < mis_n) ? band : dom_c;
      run_in = run_n;
      mis_in = mis_n;

      evt.push = sample_en && (band != alkd_pkg::BAND_GAP) && (push_short || push_long);
      evt.code = push_short ? alkd_pkg::CODE_W'(dom_ff)
                            : alkd_pkg::CODE_W'(dom_c) + alkd_pkg::LONG_OFFSET;
   end

   // tracking state; gap samples leave it alone
   always_ff @(posedge clock) begin
      if (reset) begin
         dom_ff <= alkd_pkg::BAND_GAP;
         run_ff <= '0;
         mis_ff <= '0;
      end else if (sample_en && band != alkd_pkg::BAND_GAP) begin
         dom_ff <= dom_in;
         run_ff <= run_in;
         mis_ff <= mis_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/alkd_queue.sv -----
// ----------------------------------------------------------------------------
// alkd_queue
// Overwriting key ring: code memory with one write and one registered read
// port, valid bit per entry, read and write pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module alkd_queue #(
   parameter int QUEUE_DEPTH = alkd_pkg::DEF_QUEUE_DEPTH
) (
   input  wire                              clock,
   input  wire                              reset,
   input  alkd_pkg::qcmd_type               cmd,
   output logic [alkd_pkg::CODE_W-1:0]      rd_code
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

   logic [alkd_pkg::CODE_W-1:0] queue_mem [QUEUE_DEPTH];
   logic [alkd_pkg::CODE_W-1:0] rdata_ff;
   logic                        hit_ff, hit_in;
   logic [QUEUE_DEPTH-1:0]      valid_ff, valid_in;
   logic [PTR_W-1:0]            wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]            last_wr, rd_addr;
   logic                        oldest_ok, rd_hit;

   // pick the oldest entry, else the newest slot
   always_comb begin
      last_wr   = (wr_ptr_ff == '0) ? LAST : wr_ptr_ff - 1'b1;
      oldest_ok = valid_ff[rd_ptr_ff];
      rd_addr   = oldest_ok ? rd_ptr_ff : last_wr;
      rd_hit    = valid_ff[rd_addr];
   end

   // pointer and valid bit update
   always_comb begin
      valid_in  = valid_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      hit_in    = hit_ff;
      if (cmd.en) begin
         hit_in = cmd.pop && rd_hit;
      end
      if (cmd.pop) begin
         valid_in[rd_addr] = 1'b0;
         if (oldest_ok) begin
            rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
         end else if (rd_hit) begin
            rd_ptr_in = last_wr;
         end
      end
      if (cmd.push) begin
         valid_in[wr_ptr_ff] = 1'b1;
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         hit_ff    <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         hit_ff    <= hit_in;
      end
   end

   // code memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         queue_mem[wr_ptr_ff] <= cmd.push_code;
      end
      if (cmd.pop) begin
         rdata_ff <= queue_mem[rd_addr];
      end
   end

   // an invalid slot reads as no key
   assign rd_code = hit_ff ? rdata_ff : alkd_pkg::CODE_NONE;

endmodule

`default_nettype wire

// ----- rtl/adc_ladder_keypad_decoder.sv -----
// ----------------------------------------------------------------------------
// adc_ladder_keypad_decoder
// Resistor-ladder keypad decoder: classifies ADC samples into key bands,
// detects short and long presses and keeps key codes in an overwriting ring.
//
//   channel   dir  handshake        payload
//   req_ch    in   valid / ready    req_type, adc_sample, inject_code
//   rsp_ch    out  valid / ready    key_code, band, event_pushed
//   csr_ch    in   valid / ready    index, data (ready is always high)
//
// One word is accepted per cycle while rsp_ch keeps taking words; the response
// word goes through the registered ring memory read in stage 1 and then
// through the output register.
// Tracking state and ring pointers update in the accept cycle, so the next
// word sees them at once. Reset is synchronous and needs no clearing pass.
// While rsp_ch stalls with the output register full, stage 1 can still take
// one word; once it holds one, ready stays low until the output is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "adc_ladder_keypad_decoder_defines.svh"

module adc_ladder_keypad_decoder #(
   parameter int QUEUE_DEPTH = alkd_pkg::DEF_QUEUE_DEPTH,
   parameter int ADC_BITS    = alkd_pkg::DEF_ADC_BITS,
   parameter int COUNT_BITS  = alkd_pkg::DEF_COUNT_BITS
) (
   input  wire            clock,
   input  wire            reset,
   alkd_req_if.sink       req_ch,
   alkd_rsp_if.source     rsp_ch,
   alkd_csr_if.sink       csr_ch
);

   logic                          accept, is_sample, is_read, is_inject;
   alkd_pkg::cfg_wr_type          cfg;
   alkd_pkg::event_type           evt;
   alkd_pkg::qcmd_type            qcmd;
   logic [alkd_pkg::BAND_W-1:0]   band;
   logic [alkd_pkg::CODE_W-1:0]   q_code;

   logic                          s1_valid_ff, s1_valid_in, s1_adv;
   logic [alkd_pkg::BAND_W-1:0]   s1_band_ff;
   logic                          s1_pushed_ff;
   logic                          out_valid_ff, out_valid_in;
   logic [alkd_pkg::CODE_W-1:0]   out_code_ff;
   logic [alkd_pkg::BAND_W-1:0]   out_band_ff;
   logic                          out_pushed_ff;

   // register writes
   assign csr_ch.ready = 1'b1;
   assign cfg.en    = csr_ch.valid;
   assign cfg.index = csr_ch.index;
   assign cfg.data  = csr_ch.data;

   // request decode
   assign s1_adv       = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_sample    = accept && (req_ch.req_type == alkd_pkg::REQ_SAMPLE);
   assign is_read      = accept && (req_ch.req_type == alkd_pkg::REQ_READ);
   assign is_inject    = accept && (req_ch.req_type == alkd_pkg::REQ_INJECT);

   alkd_tracker #(
      .ADC_BITS   (ADC_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_tracker (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .sample_en (is_sample),
      .sample    (req_ch.adc_sample),
      .band      (band),
      .evt       (evt)
   );

   // ring command: at most one push or one pop per word
   always_comb begin
      qcmd.en        = accept;
      qcmd.push      = is_inject || evt.push;
      qcmd.push_code = is_inject ? req_ch.inject_code : evt.code;
      qcmd.pop       = is_read;
   end

   alkd_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .cmd     (qcmd),
      .rd_code (q_code)
   );

   // stage 1: waits on the memory read
   assign s1_valid_in = accept || (s1_valid_ff && !s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_band_ff   <= is_sample ? band : alkd_pkg::BAND_GAP;
         s1_pushed_ff <= qcmd.push;
      end
   end

   // output register
   assign out_valid_in = s1_adv || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_code_ff   <= q_code;
         out_band_ff   <= s1_band_ff;
         out_pushed_ff <= s1_pushed_ff;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.key_code     = out_code_ff;
   assign rsp_ch.band         = out_band_ff;
   assign rsp_ch.event_pushed = out_pushed_ff;

   // checks
   `ALKD_ASSERT(a_accept_fills_s1, accept |=> s1_valid_ff, "accepted word lost before stage 1")
   `ALKD_ASSERT(a_s1_holds, (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_band_ff)), "stalled stage 1 changed")
   `ALKD_ASSERT(a_code_only_on_read, (rsp_ch.valid && rsp_ch.key_code != alkd_pkg::CODE_NONE) |-> (rsp_ch.band == alkd_pkg::BAND_GAP), "key code and band on one word")
   `ALKD_ASSERT_ALWAYS(a_reset_empty, reset |=> (!rsp_ch.valid && !s1_valid_ff), "pipeline not empty after reset")

endmodule

`default_nettype wire

// ----- tb/keypad_decode_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keypad_decode_checker
// Watches the request, response and register channels of the keypad decoder.
// Keeps its own copy of the band thresholds, press tracking and key ring,
// works out the response of every accepted request word and compares each
// accepted response word with the oldest one still waiting.
// ----------------------------------------------------------------------------

module keypad_decode_checker
   import alkd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_sample,
   input  logic [3:0]  req_code,
   // response channel
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_key_code,
   input  logic [2:0]  rsp_band,
   input  logic        rsp_event_pushed,
   // register write channel
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic [CODE_W-1:0] key_code;
      logic [BAND_W-1:0] band;
      logic              event_pushed;
   } keypad_word_t;

   localparam int RING_DEPTH = 16;

   // register copies
   logic [THR_W-1:0]   band_upper [4];
   logic [THR_W-1:0]   release_above;
   logic [LIMIT_W-1:0] debounce_limit;
   logic [LIMIT_W-1:0] long_limit;

   // key ring and press tracking
   logic [CODE_W-1:0]  ring_code  [RING_DEPTH];
   logic               ring_valid [RING_DEPTH];
   logic [3:0]         wr_ptr;
   logic [3:0]         rd_ptr;
   logic [BAND_W-1:0]  dom_band;
   logic [15:0]        run_cnt;
   logic [15:0]        miss_cnt;

   keypad_word_t expected_words [$];

   function automatic logic [BAND_W-1:0] band_of(input logic [7:0] s);
      if (s < band_upper[0]) return BAND_KEY1;
      if (s >= band_upper[0] && s < band_upper[1]) return BAND_KEY2;
      if (s >= band_upper[1] && s < band_upper[2]) return BAND_KEY3;
      if (s >= band_upper[2] && s < band_upper[3]) return BAND_KEY4;
      if (s > release_above) return BAND_RELEASE;
      return BAND_GAP;
   endfunction

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic is_key(input logic [BAND_W-1:0] b);
      return (b >= BAND_KEY1) && (b <= BAND_KEY4);
   endfunction

   task automatic push_code(input logic [CODE_W-1:0] code);
      ring_code[wr_ptr]  = code;
      ring_valid[wr_ptr] = 1'b1;
      wr_ptr             = wr_ptr + 4'd1;
   endtask

   // oldest code, else the newest one
   task automatic pop_code(output logic [CODE_W-1:0] code);
      logic [3:0] newest;
      code = CODE_NONE;
      if (ring_valid[rd_ptr]) begin
         code               = ring_code[rd_ptr];
         ring_valid[rd_ptr] = 1'b0;
         ring_code[rd_ptr]  = CODE_NONE;
         rd_ptr             = rd_ptr + 4'd1;
      end else begin
         newest = wr_ptr - 4'd1;
         if (ring_valid[newest]) begin
            code   = ring_code[newest];
            rd_ptr = newest;
         end
         ring_valid[newest] = 1'b0;
         ring_code[newest]  = CODE_NONE;
      end
   endtask

   // dominant band tracking, short and long press detection
   task automatic track_sample(input logic [BAND_W-1:0] b, output logic pushed);
      logic [15:0] prior;
      pushed = 1'b0;
      if (b != BAND_GAP) begin
         // debounced release: short code unless the long count was reached
         if (b == BAND_RELEASE && run_cnt > debounce_limit) begin
            if (is_key(dom_band) && run_cnt < long_limit) begin
               push_code({1'b0, dom_band});
               pushed = 1'b1;
            end
            run_cnt  = '0;
            miss_cnt = '0;
            dom_band = BAND_GAP;
         end
         if (b == dom_band) begin
            prior   = run_cnt;
            run_cnt = sat_inc(run_cnt);
            if (run_cnt != prior && run_cnt == long_limit && is_key(dom_band)) begin
               push_code({1'b0, dom_band} + LONG_OFFSET);
               pushed = 1'b1;
            end
         end else begin
            miss_cnt = sat_inc(miss_cnt);
         end
         if (run_cnt < miss_cnt) dom_band = b;
      end
   endtask

   task automatic predict_keypad_word(input logic [1:0] kind_bits, input logic [7:0] smp,
                                      input logic [3:0] code, output keypad_word_t exp);
      req_kind_type kind;
      kind = req_kind_type'(kind_bits);
      exp  = '0;
      case (kind)
         REQ_SAMPLE: begin
            exp.band = band_of(smp);
            track_sample(exp.band, exp.event_pushed);
         end
         REQ_READ: begin
            pop_code(exp.key_code);
         end
         REQ_INJECT: begin
            push_code(code);
            exp.event_pushed = 1'b1;
         end
         default: begin
         end
      endcase
   endtask

   task automatic reset_model();
      band_upper[0]  = RST_BAND1_UPPER;
      band_upper[1]  = RST_BAND2_UPPER;
      band_upper[2]  = RST_BAND3_UPPER;
      band_upper[3]  = RST_BAND4_UPPER;
      release_above  = RST_RELEASE_ABOVE;
      debounce_limit = RST_DEBOUNCE_COUNT;
      long_limit     = RST_LONG_COUNT;
      for (int i = 0; i < RING_DEPTH; i++) begin
         ring_code[i]  = CODE_NONE;
         ring_valid[i] = 1'b0;
      end
      wr_ptr   = '0;
      rd_ptr   = '0;
      dom_band = BAND_GAP;
      run_cnt  = '0;
      miss_cnt = '0;
      expected_words.delete();
   endtask

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // per-edge monitor: compare first, then register writes, then prediction
   always @(posedge clock) begin : monitor
      keypad_word_t exp;
      if (reset) begin
         reset_model();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("response word with no expectation waiting");
               fail_count = fail_count + 1;
            end else begin
               exp = expected_words.pop_front();
               if (rsp_key_code !== exp.key_code) begin
                  $error("key_code: expected %0d, actual %0d", exp.key_code, rsp_key_code);
                  fail_count = fail_count + 1;
               end
               if (rsp_band !== exp.band) begin
                  $error("band: expected %0d, actual %0d", exp.band, rsp_band);
                  fail_count = fail_count + 1;
               end
               if (rsp_event_pushed !== exp.event_pushed) begin
                  $error("event_pushed: expected %0d, actual %0d",
                         exp.event_pushed, rsp_event_pushed);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_BAND1_UPPER:    band_upper[0]  = csr_data[7:0];
               REG_BAND2_UPPER:    band_upper[1]  = csr_data[7:0];
               REG_BAND3_UPPER:    band_upper[2]  = csr_data[7:0];
               REG_BAND4_UPPER:    band_upper[3]  = csr_data[7:0];
               REG_RELEASE_ABOVE:  release_above  = csr_data[7:0];
               REG_DEBOUNCE_COUNT: debounce_limit = csr_data;
               REG_LONG_COUNT:     long_limit     = csr_data;
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            predict_keypad_word(req_type, req_sample, req_code, exp);
            expected_words.push_back(exp);
         end
      end
      pending_count = expected_words.size();
   end

endmodule

// ----- tb/adc_ladder_keypad_decoder_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adc_ladder_keypad_decoder_tb
// Drives the keypad decoder with directed samples, reads and injects and
// random press sequences over several register settings and idle/stall
// mixes. A checker beside the block predicts and compares every response
// word; this module only makes stimulus and reports.
// ----------------------------------------------------------------------------

module adc_ladder_keypad_decoder_tb;
   import alkd_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASE_WORDS = 225;
   localparam int NUM_REGS    = 7;

   logic clock;
   logic reset;
   int   idle_pct;
   int   stall_pct;
   int   word_count;
   int   cycle_count;
   int   fail_count;
   int   pending_count;

   logic [15:0]          reg_val   [NUM_REGS];
   logic [CSR_IDX_W-1:0] reg_index [NUM_REGS];

   alkd_req_if #(.ADC_BITS(8)) req_if ();
   alkd_rsp_if                 rsp_if ();
   alkd_csr_if                 csr_if ();

   adc_ladder_keypad_decoder u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   keypad_decode_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_if.valid),
      .req_ready        (req_if.ready),
      .req_type         (req_if.req_type),
      .req_sample       (req_if.adc_sample),
      .req_code         (req_if.inject_code),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_key_code     (rsp_if.key_code),
      .rsp_band         (rsp_if.band),
      .rsp_event_pushed (rsp_if.event_pushed),
      .csr_valid        (csr_if.valid),
      .csr_ready        (csr_if.ready),
      .csr_index        (csr_if.index),
      .csr_data         (csr_if.data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // response side stalls
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   // sample that lands in band b under the current thresholds, if any does
   function automatic logic [7:0] pick_sample(input logic [BAND_W-1:0] b);
      int lo;
      int hi;
      lo = 0;
      hi = 0;
      case (b)
         BAND_KEY1:    begin lo = 0;                  hi = reg_val[REG_BAND1_UPPER]; end
         BAND_KEY2:    begin lo = reg_val[REG_BAND1_UPPER]; hi = reg_val[REG_BAND2_UPPER]; end
         BAND_KEY3:    begin lo = reg_val[REG_BAND2_UPPER]; hi = reg_val[REG_BAND3_UPPER]; end
         BAND_KEY4:    begin lo = reg_val[REG_BAND3_UPPER]; hi = reg_val[REG_BAND4_UPPER]; end
         BAND_RELEASE: begin lo = reg_val[REG_RELEASE_ABOVE] + 1; hi = 256; end
         default:      begin lo = reg_val[REG_BAND4_UPPER]; hi = reg_val[REG_RELEASE_ABOVE] + 1; end
      endcase
      if (lo < hi) return 8'($urandom_range(hi - 1, lo));
      return 8'($urandom_range(255));
   endfunction

   // one request word; called and returns at a falling edge, valid left high
   task automatic send_word(input req_kind_type kind, input logic [7:0] smp,
                            input logic [3:0] code);
      logic idled;
      idled = 1'b0;
      while ($urandom_range(99) < idle_pct) begin
         if (!idled) req_if.valid <= 1'b0;
         idled = 1'b1;
         @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.req_type    <= kind;
      req_if.adc_sample  <= smp;
      req_if.inject_code <= code;
      do @(posedge clock); while (!req_if.ready);
      word_count = word_count + 1;
      @(negedge clock);
   endtask

   // stop sending and wait until every expected response word has come
   task automatic hold_off();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   // write all registers from reg_val while the block is idle
   task automatic program_regs();
      hold_off();
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_if.valid <= 1'b1;
         csr_if.index <= reg_index[i];
         csr_if.data  <= reg_val[i];
         do @(posedge clock); while (!csr_if.ready);
         @(negedge clock);
      end
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_regs(input int b1, input int b2, input int b3, input int b4,
                           input int rel, input int deb, input int lng);
      reg_val[REG_BAND1_UPPER]    = 16'(b1);
      reg_val[REG_BAND2_UPPER]    = 16'(b2);
      reg_val[REG_BAND3_UPPER]    = 16'(b3);
      reg_val[REG_BAND4_UPPER]    = 16'(b4);
      reg_val[REG_RELEASE_ABOVE]  = 16'(rel);
      reg_val[REG_DEBOUNCE_COUNT] = 16'(deb);
      reg_val[REG_LONG_COUNT]     = 16'(lng);
      program_regs();
   endtask

   // held key with some noise, then release and a few gap samples
   task automatic press_key(input logic [BAND_W-1:0] key, input int len);
      int n;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 8)
            send_word(REQ_SAMPLE, 8'($urandom_range(255)), 4'($urandom_range(15)));
         else
            send_word(REQ_SAMPLE, pick_sample(key), 4'($urandom_range(15)));
      end
      n = $urandom_range(3, 1);
      for (int i = 0; i < n; i++)
         send_word(REQ_SAMPLE, pick_sample(BAND_RELEASE), 4'($urandom_range(15)));
      n = $urandom_range(2);
      for (int i = 0; i < n; i++)
         send_word(REQ_SAMPLE, pick_sample(BAND_GAP), 4'($urandom_range(15)));
   endtask

   task automatic run_phase(input int words, input int max_len);
      int stop_at;
      int r;
      stop_at = word_count + words;
      while (word_count < stop_at) begin
         r = $urandom_range(99);
         if (r < 62) begin
            press_key(BAND_KEY1 + 3'($urandom_range(3)), $urandom_range(max_len, 1));
         end else if (r < 80) begin
            send_word(REQ_READ, 8'($urandom_range(255)), 4'($urandom_range(15)));
         end else if (r < 88) begin
            send_word(REQ_INJECT, 8'($urandom_range(255)), 4'($urandom_range(15)));
         end else if (r < 91) begin
            send_word(REQ_NOP, 8'($urandom_range(255)), 4'($urandom_range(15)));
         end else if (r < 93) begin
            // overrun the ring
            for (int i = 0; i < 18; i++)
               send_word(REQ_INJECT, 8'($urandom_range(255)), 4'($urandom_range(15)));
         end else if (r < 95) begin
            // six reads in a row, past empty if the ring holds fewer codes
            for (int i = 0; i < 6; i++)
               send_word(REQ_READ, 8'($urandom_range(255)), 4'($urandom_range(15)));
         end else if (r < 99) begin
            send_word(req_kind_type'($urandom_range(3)), 8'($urandom_range(255)),
                      4'($urandom_range(15)));
         end else begin
            hold_off();
         end
      end
   endtask

   task automatic set_mode(input int idle, input int stall);
      idle_pct  = idle;
      stall_pct = stall;
   endtask

   // stimulus and verdict
   initial begin : stimulus
      logic [7:0] edge_samples [12];
      int         t1;
      int         t2;
      int         t3;
      int         t4;
      edge_samples = '{8'd0, 8'd99, 8'd100, 8'd139, 8'd140, 8'd179,
                       8'd180, 8'd239, 8'd240, 8'd245, 8'd246, 8'd255};
      reset              = 1'b1;
      idle_pct           = 0;
      stall_pct          = 0;
      word_count         = 0;
      req_if.valid       = 1'b0;
      req_if.req_type    = REQ_NOP;
      req_if.adc_sample  = '0;
      req_if.inject_code = '0;
      rsp_if.ready       = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.index       = REG_BAND1_UPPER;
      csr_if.data        = '0;
      reg_index = '{REG_BAND1_UPPER, REG_BAND2_UPPER, REG_BAND3_UPPER, REG_BAND4_UPPER,
                    REG_RELEASE_ABOVE, REG_DEBOUNCE_COUNT, REG_LONG_COUNT};
      reg_val[REG_BAND1_UPPER]    = RST_BAND1_UPPER;
      reg_val[REG_BAND2_UPPER]    = RST_BAND2_UPPER;
      reg_val[REG_BAND3_UPPER]    = RST_BAND3_UPPER;
      reg_val[REG_BAND4_UPPER]    = RST_BAND4_UPPER;
      reg_val[REG_RELEASE_ABOVE]  = RST_RELEASE_ABOVE;
      reg_val[REG_DEBOUNCE_COUNT] = RST_DEBOUNCE_COUNT;
      reg_val[REG_LONG_COUNT]     = RST_LONG_COUNT;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: band edges under reset thresholds, gaps and release
      foreach (edge_samples[i]) send_word(REQ_SAMPLE, edge_samples[i], 4'd0);
      // reads on an empty ring, injected zero, fifteen and nine
      send_word(REQ_READ,   8'd0,   4'd0);
      send_word(REQ_INJECT, 8'd0,   4'd0);
      send_word(REQ_READ,   8'd0,   4'd0);
      send_word(REQ_READ,   8'd0,   4'd0);
      send_word(REQ_INJECT, 8'd255, 4'd15);
      send_word(REQ_INJECT, 8'd0,   4'd9);
      send_word(REQ_READ,   8'd255, 4'd15);
      send_word(REQ_READ,   8'd0,   4'd0);
      send_word(REQ_NOP,    8'd255, 4'd15);
      // debounced short press of key 1
      for (int i = 0; i < 5; i++) send_word(REQ_SAMPLE, 8'd50, 4'd0);
      send_word(REQ_SAMPLE, 8'd250, 4'd0);
      send_word(REQ_READ,   8'd0,   4'd0);

      // random phases over several settings and idle mixes
      set_mode(62, 0);
      run_phase(PHASE_WORDS, 40);

      set_regs(100, 140, 180, 240, 245, 0, 1);
      set_mode(0, 62);
      run_phase(PHASE_WORDS, 4);

      set_regs(100, 140, 180, 240, 245, 2, 6);
      set_mode(26, 26);
      run_phase(PHASE_WORDS, 10);

      set_regs(0, 1, 254, 255, 255, 65535, 65535);
      set_mode(0, 0);
      run_phase(PHASE_WORDS, 12);

      set_regs(255, 255, 255, 255, 0, 1, 3);
      set_mode(62, 0);
      run_phase(PHASE_WORDS, 8);

      t1 = $urandom_range(80, 20);
      t2 = t1 + $urandom_range(50, 1);
      t3 = t2 + $urandom_range(50, 1);
      t4 = t3 + $urandom_range(40, 1);
      set_regs(t1, t2, t3, t4, t4 + $urandom_range(20), $urandom_range(5),
               $urandom_range(12, 1));
      set_mode(0, 62);
      run_phase(PHASE_WORDS, reg_val[REG_LONG_COUNT] + 4);

      set_regs($urandom_range(255), $urandom_range(255), $urandom_range(255),
               $urandom_range(255), $urandom_range(255), $urandom_range(8),
               $urandom_range(20, 1));
      set_mode(26, 26);
      run_phase(PHASE_WORDS, 24);

      // drain and let the output pipeline settle
      hold_off();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/alkd_pkg.sv
rtl/alkd_channels.sv
rtl/alkd_tracker.sv
rtl/alkd_queue.sv
rtl/adc_ladder_keypad_decoder.sv
tb/keypad_decode_checker.sv
tb/adc_ladder_keypad_decoder_tb.sv
